// ===== sv/gqi_pkg.sv =====
// Package for the gyro quaternion integrator: formats, constants, stage map.
// Shared by the pipelined square root and divider, the top level, the checker
// and the testbench. No dependencies.
package gqi_pkg;

  localparam int ANGLE_ITERATIONS = 24;
  localparam int CORDIC_N = (ANGLE_ITERATIONS < 32) ? ANGLE_ITERATIONS : 32;

  localparam int RAD_W       = 70;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int REM_W       = ROOT_W + 3;
  localparam int SQRT_STAGES = ROOT_W;

  localparam int NUM_W      = 64;
  localparam int DEN_W      = 35;
  localparam int QUO_W      = 32;
  localparam int DIV_STAGES = QUO_W;

  localparam logic [63:0] PHASE_K     = 64'h517CC1B727220A95;
  localparam logic [31:0] PI_Q30      = 32'hC90FDAA2;
  localparam logic [31:0] GAIN_Q30    = 32'h26DD3B6A;
  localparam logic [31:0] ONE_Q30     = 32'h40000000;
  localparam logic [31:0] EIGHTH_TURN = 32'h20000000;
  localparam logic signed [35:0] P_MAX = 36'sd8589934591;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  localparam int S_IN   = 0;
  localparam int S_W    = 1;
  localparam int S_SQ   = 2;
  localparam int S_RAD  = 3;
  localparam int S_PR   = S_RAD + SQRT_STAGES + 1;
  localparam int S_PP   = S_PR + 1;
  localparam int S_AB   = S_PP + 1;
  localparam int S_PH   = S_AB + 1;
  localparam int S_ZP   = S_PH + 1;
  localparam int S_Z0   = S_ZP + 1;
  localparam int S_CS   = S_Z0 + CORDIC_N + 1;
  localparam int S_NUM  = S_CS + 1;
  localparam int S_D    = S_NUM + DIV_STAGES + 1;
  localparam int S_HT   = S_D + 1;
  localparam int S_P    = S_HT + 1;
  localparam int S_PSQ  = S_P + 1;
  localparam int S_R2   = S_PSQ + 1;
  localparam int S_N2   = S_R2 + SQRT_STAGES + 1;
  localparam int S_OUT  = S_N2 + DIV_STAGES + 1;
  localparam int N_STAGES = S_OUT + 1;

  localparam int OUTST_W = $clog2(N_STAGES + 3);
  localparam logic [1:0] FIFO_FULL = 2'd2;

  typedef struct packed {
    logic [3:0][31:0] q;
    logic [2:0][31:0] w;
    logic [23:0]      dt;
    logic [32:0]      nw;
    logic             nz1;
    logic [1:0]       quad;
    logic [31:0]      c;
    logic [2:0]       dneg;
    logic [3:0][33:0] p;
    logic             nz2;
  } side_t;

  typedef logic [3:0][31:0] res_t;

endpackage

// ===== sv/gqi_if.sv =====
// Handshake channels of the gyro quaternion integrator: input item and result item.
// Depends on nothing but the SystemVerilog interface construct.
interface gqi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quat_w_in;
  logic signed [31:0] quat_x_in;
  logic signed [31:0] quat_y_in;
  logic signed [31:0] quat_z_in;
  logic signed [31:0] rate_x;
  logic signed [31:0] rate_y;
  logic signed [31:0] rate_z;
  logic signed [31:0] bias_x;
  logic signed [31:0] bias_y;
  logic signed [31:0] bias_z;
  logic        [23:0] step_time;

  modport source (output valid, quat_w_in, quat_x_in, quat_y_in, quat_z_in,
                  rate_x, rate_y, rate_z, bias_x, bias_y, bias_z, step_time,
                  input ready);
  modport sink (input valid, quat_w_in, quat_x_in, quat_y_in, quat_z_in,
                rate_x, rate_y, rate_z, bias_x, bias_y, bias_z, step_time,
                output ready);
endinterface

interface gqi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quat_w_out;
  logic signed [31:0] quat_x_out;
  logic signed [31:0] quat_y_out;
  logic signed [31:0] quat_z_out;

  modport source (output valid, quat_w_out, quat_x_out, quat_y_out, quat_z_out,
                  input ready);
  modport sink (input valid, quat_w_out, quat_x_out, quat_y_out, quat_z_out,
                output ready);
endinterface

// ===== sv/gyro_quaternion_integrate_core.sv =====
// Throughput: one item per cycle; the whole pipeline holds only when the two-entry
// output buffer is full, so one finished result may wait while input is still taken.
// The rate is set by the fully pipelined square roots, CORDIC and dividers.
// Reset clears stage valid bits and the output buffer; payload registers keep no reset.
// Depends on gqi_pkg, gqi_if, gqi_sqrt and gqi_div.
module gyro_quaternion_integrate_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  gqi_in_if.sink   in_i,
  gqi_out_if.source out_o
);
  import gqi_pkg::*;

  function automatic logic [32:0] mag34(input logic [33:0] v);
    logic [33:0] m;
    m = v[33] ? (34'd0 - v) : v;
    return m[32:0];
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  logic adv;
  logic vld_q [N_STAGES];
  side_t side_q [N_STAGES];
  side_t side_d [N_STAGES];

  logic [2:0][31:0] rate_q, bias_q;
  logic [2:0][31:0] wsat;
  logic [63:0] sq_q [3];
  logic [RAD_W-1:0] rad_q, rad2_q;
  logic [ROOT_W-1:0] root1, root2;
  logic [56:0] pr_q;
  logic [60:0] pp00_q, pp01_q;
  logic [59:0] pp10_q, pp11_q;
  logic [93:0] a_q;
  logic [92:0] b_q;
  logic [127:0] t_sum;
  logic [31:0] r32;
  logic signed [30:0] res_d, res_q;
  logic signed [63:0] zp_q;
  logic signed [33:0] cx_q [CORDIC_N+1];
  logic signed [33:0] cy_q [CORDIC_N+1];
  logic signed [33:0] cz_q [CORDIC_N+1];
  logic signed [33:0] c_sel, s_sel, s_q;
  logic [31:0] s_mag;
  logic [NUM_W-1:0] num1_q [3];
  logic [QUO_W-1:0] quo1 [3];
  logic signed [31:0] d_q [4];
  logic signed [33:0] h_q [4][4];
  logic signed [35:0] psum [4];
  logic [3:0][33:0] p_cl;
  logic [65:0] psq_q [4];
  logic [NUM_W-1:0] num2_q [4];
  logic [DEN_W-1:0] den2_q;
  logic [QUO_W-1:0] quo2 [4];
  res_t fin_q;

  logic [1:0] cnt_q;
  logic wp_q, rp_q, push, pop;
  res_t fifo_q [2];
  res_t rd;

  assign adv = (cnt_q != FIFO_FULL);
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N_STAGES; k++) vld_q[k] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_i.valid;
      for (int k = 1; k < N_STAGES; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [32:0] diff;
      diff = $signed({rate_q[i][31], rate_q[i]}) - $signed({bias_q[i][31], bias_q[i]});
      if (diff[32] != diff[31]) wsat[i] = diff[32] ? 32'h80000000 : 32'h7FFFFFFF;
      else                      wsat[i] = diff[31:0];
    end
  end

  always_comb begin
    t_sum = 128'(a_q) + 128'({b_q, 29'b0});
    r32   = t_sum[113:82] + EIGHTH_TURN;
    res_d = $signed({1'b0, r32[29:0]}) - $signed(31'(EIGHTH_TURN));
  end

  always_comb begin
    case (side_q[S_CS-1].quad)
      QUAD_I:   begin c_sel = cx_q[CORDIC_N];          s_sel = cy_q[CORDIC_N];          end
      QUAD_II:  begin c_sel = 34'sd0 - cy_q[CORDIC_N]; s_sel = cx_q[CORDIC_N];          end
      QUAD_III: begin c_sel = 34'sd0 - cx_q[CORDIC_N]; s_sel = 34'sd0 - cy_q[CORDIC_N]; end
      default:  begin c_sel = cy_q[CORDIC_N];          s_sel = 34'sd0 - cx_q[CORDIC_N]; end
    endcase
  end

  always_comb begin
    logic [33:0] sm;
    sm    = s_q[33] ? (34'd0 - s_q) : s_q;
    s_mag = sm[31:0];
  end

  always_comb begin
    psum[0] = h_q[0][0] - h_q[1][1] - h_q[2][2] - h_q[3][3];
    psum[1] = h_q[0][1] + h_q[1][0] + h_q[2][3] - h_q[3][2];
    psum[2] = h_q[0][2] - h_q[1][3] + h_q[2][0] + h_q[3][1];
    psum[3] = h_q[0][3] + h_q[1][2] - h_q[2][1] + h_q[3][0];
    for (int i = 0; i < 4; i++) begin
      if (psum[i] > P_MAX)        p_cl[i] = P_MAX[33:0];
      else if (psum[i] < -P_MAX)  p_cl[i] = 34'd0 - P_MAX[33:0];
      else                        p_cl[i] = psum[i][33:0];
    end
  end

  always_comb begin
    side_d[0]      = '0;
    side_d[0].q[0] = in_i.quat_w_in;
    side_d[0].q[1] = in_i.quat_x_in;
    side_d[0].q[2] = in_i.quat_y_in;
    side_d[0].q[3] = in_i.quat_z_in;
    side_d[0].dt   = in_i.step_time;
    for (int k = 1; k < N_STAGES; k++) side_d[k] = side_q[k-1];
    side_d[S_W].w     = wsat;
    side_d[S_PR].nw   = root1[32:0];
    side_d[S_PR].nz1  = (root1 != '0);
    side_d[S_PH].quad = r32[31:30];
    side_d[S_CS].c    = c_sel[31:0];
    for (int i = 0; i < 3; i++)
      side_d[S_NUM].dneg[i] = side_q[S_NUM-1].w[i][31] ^ s_q[33];
    side_d[S_P].p     = p_cl;
    side_d[S_N2].nz2  = (root2 != '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q <= side_d;
      rate_q <= {in_i.rate_z, in_i.rate_y, in_i.rate_x};
      bias_q <= {in_i.bias_z, in_i.bias_y, in_i.bias_x};
      for (int i = 0; i < 3; i++)
        sq_q[i] <= mag32(side_q[S_SQ-1].w[i]) * mag32(side_q[S_SQ-1].w[i]);
      rad_q  <= RAD_W'(sq_q[0]) + RAD_W'(sq_q[1]) + RAD_W'(sq_q[2]);
      pr_q   <= root1[32:0] * side_q[S_PR-1].dt;
      pp00_q <= pr_q[28:0] * PHASE_K[31:0];
      pp01_q <= pr_q[28:0] * PHASE_K[63:32];
      pp10_q <= pr_q[56:29] * PHASE_K[31:0];
      pp11_q <= pr_q[56:29] * PHASE_K[63:32];
      a_q    <= 94'(pp00_q) + 94'({pp01_q, 32'b0});
      b_q    <= 93'(pp10_q) + 93'({pp11_q, 32'b0});
      res_q  <= res_d;
      zp_q   <= res_q * $signed({1'b0, PI_Q30});
      cx_q[0] <= $signed({2'b00, GAIN_Q30});
      cy_q[0] <= '0;
      cz_q[0] <= $signed({zp_q[63], zp_q[63:31]});
      s_q    <= s_sel;
      for (int i = 0; i < 3; i++)
        num1_q[i] <= mag32(side_q[S_NUM-1].w[i]) * s_mag;
      d_q[0] <= side_q[S_D-1].nz1 ? $signed(side_q[S_D-1].c) : $signed(ONE_Q30);
      for (int i = 0; i < 3; i++)
        d_q[i+1] <= !side_q[S_D-1].nz1 ? 32'sd0 :
                    side_q[S_D-1].dneg[i] ? $signed(32'd0 - quo1[i]) : $signed(quo1[i]);
      for (int i = 0; i < 4; i++)
        psq_q[i] <= mag34(side_q[S_PSQ-1].p[i]) * mag34(side_q[S_PSQ-1].p[i]);
      rad2_q <= RAD_W'(psq_q[0]) + RAD_W'(psq_q[1]) + RAD_W'(psq_q[2]) + RAD_W'(psq_q[3]);
      for (int i = 0; i < 4; i++)
        num2_q[i] <= {1'b0, mag34(side_q[S_N2-1].p[i]), 30'b0};
      den2_q <= root2;
      for (int i = 0; i < 4; i++)
        fin_q[i] <= !side_q[S_OUT-1].nz2 ? 32'd0 :
                    side_q[S_OUT-1].p[i][33] ? (32'd0 - quo2[i]) : quo2[i];
    end
  end

  for (genvar k = 0; k < CORDIC_N; k++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!cz_q[k][33]) begin
          cx_q[k+1] <= cx_q[k] - (cy_q[k] >>> k);
          cy_q[k+1] <= cy_q[k] + (cx_q[k] >>> k);
          cz_q[k+1] <= cz_q[k] - $signed({2'b00, ATAN_Q30[k]});
        end else begin
          cx_q[k+1] <= cx_q[k] + (cy_q[k] >>> k);
          cy_q[k+1] <= cy_q[k] - (cx_q[k] >>> k);
          cz_q[k+1] <= cz_q[k] + $signed({2'b00, ATAN_Q30[k]});
        end
      end
    end
  end

  for (genvar a = 0; a < 4; a++) begin : g_ha
    for (genvar b = 0; b < 4; b++) begin : g_hb
      logic signed [63:0] hp;
      assign hp = $signed(side_q[S_HT-1].q[a]) * d_q[b];
      always_ff @(posedge clk_i) begin
        if (adv) h_q[a][b] <= hp[63:30];
      end
    end
  end

  gqi_sqrt u_sqrt_rate (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad_q),
    .root_o (root1)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div_rate
    gqi_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num1_q[i]),
      .den_i ({2'b00, side_q[S_NUM].nw}),
      .quo_o (quo1[i])
    );
  end

  gqi_sqrt u_sqrt_norm (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad2_q),
    .root_o (root2)
  );

  for (genvar i = 0; i < 4; i++) begin : g_div_norm
    gqi_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num2_q[i]),
      .den_i (den2_q),
      .quo_o (quo2[i])
    );
  end

  assign push = adv && vld_q[S_OUT];
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= fin_q;
  end

  assign rd               = fifo_q[rp_q];
  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.quat_w_out = rd[0];
  assign out_o.quat_x_out = rd[1];
  assign out_o.quat_y_out = rd[2];
  assign out_o.quat_z_out = rd[3];

endmodule

// ===== sv/gqi_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Uses widths and stage count from gqi_pkg.
module gqi_sqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [gqi_pkg::RAD_W-1:0]   rad_i,
  output logic [gqi_pkg::ROOT_W-1:0]  root_o
);
  import gqi_pkg::*;

  logic [REM_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];
  logic [RAD_W-1:0]  rad_q  [SQRT_STAGES];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [RAD_W-1:0]  rad_p;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
    end else begin : g_next
      assign rem_p  = rem_q[j-1];
      assign root_p = root_q[j-1];
      assign rad_p  = rad_q[j-1];
    end

    always_comb begin
      cur   = {rem_p, rad_p[RAD_W-1 -: 2]};
      trial = {{(REM_W-ROOT_W){1'b0}}, root_p, 2'b01};
      diff  = cur - trial;
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
        root_q[j] <= {root_p[ROOT_W-2:0], ge};
        rad_q[j]  <= {rad_p[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule

// ===== sv/gqi_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// Uses widths and stage count from gqi_pkg; quotient must fit QUO_W bits.
module gqi_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [gqi_pkg::NUM_W-1:0]  num_i,
  input  logic [gqi_pkg::DEN_W-1:0]  den_i,
  output logic [gqi_pkg::QUO_W-1:0]  quo_o
);
  import gqi_pkg::*;

  logic [DEN_W-1:0] r_q   [DIV_STAGES];
  logic [QUO_W-1:0] lo_q  [DIV_STAGES];
  logic [DEN_W-1:0] den_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [DEN_W-1:0] r_p;
    logic [QUO_W-1:0] lo_p;
    logic [DEN_W-1:0] den_p;
    logic [QUO_W-1:0] quo_p;
    logic [DEN_W:0]   cur;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (j == 0) begin : g_first
      assign r_p   = {{(DEN_W-(NUM_W-QUO_W)){1'b0}}, num_i[NUM_W-1:QUO_W]};
      assign lo_p  = num_i[QUO_W-1:0];
      assign den_p = den_i;
      assign quo_p = '0;
    end else begin : g_next
      assign r_p   = r_q[j-1];
      assign lo_p  = lo_q[j-1];
      assign den_p = den_q[j-1];
      assign quo_p = quo_q[j-1];
    end

    always_comb begin
      cur  = {r_p, lo_p[QUO_W-1]};
      diff = cur - {1'b0, den_p};
      ge   = (cur >= {1'b0, den_p});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j]   <= ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
        lo_q[j]  <= {lo_p[QUO_W-2:0], 1'b0};
        den_q[j] <= den_p;
        quo_q[j] <= {quo_p[QUO_W-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

// ===== sv/gqi_checker.sv =====
// Port-level checks for the gyro quaternion integrator, bound to the top level.
// Depends on gqi_pkg.
module gqi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_w_i,
  input logic [31:0] out_x_i,
  input logic [31:0] out_y_i,
  input logic [31:0] out_z_i
);
  import gqi_pkg::*;

  logic [OUTST_W-1:0] outst_q;
  logic in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   outst_q <= outst_q + OUTST_W'(1);
        2'b01:   outst_q <= outst_q - OUTST_W'(1);
        default: outst_q <= outst_q;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_w_i) && $stable(out_x_i)
      && $stable(out_y_i) && $stable(out_z_i))
    else $error("result item changed while stalled");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input held off with no result waiting");

  a_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> outst_q != '0)
    else $error("result item without an accepted input item");

  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      ($signed(out_w_i) <= $signed(ONE_Q30)) && ($signed(out_w_i) >= -$signed(ONE_Q30)) &&
      ($signed(out_x_i) <= $signed(ONE_Q30)) && ($signed(out_x_i) >= -$signed(ONE_Q30)) &&
      ($signed(out_y_i) <= $signed(ONE_Q30)) && ($signed(out_y_i) >= -$signed(ONE_Q30)) &&
      ($signed(out_z_i) <= $signed(ONE_Q30)) && ($signed(out_z_i) >= -$signed(ONE_Q30)))
    else $error("normalized component beyond unit magnitude");

endmodule

bind gyro_quaternion_integrate_core gqi_checker u_gqi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_w_i     (out_o.quat_w_out),
  .out_x_i     (out_o.quat_x_out),
  .out_y_i     (out_o.quat_y_out),
  .out_z_i     (out_o.quat_z_out)
);

// ===== tb/sv/tb.sv =====
// Testbench for gyro_quaternion_integrate_core: random and directed IMU items,
// bit-exact attitude prediction, in-order result checking under random stalls.
// Depends on gqi_pkg, gqi_if and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gqi_pkg::*;

  typedef struct {
    logic signed [31:0] q [4];
    logic signed [31:0] rate [3];
    logic signed [31:0] bias [3];
    logic        [23:0] dt;
  } imu_item_t;

  class attitude_board;
    res_t pending [$];
    int   errors;
    int   matched;

    function logic [34:0] isqrt(logic [127:0] v);
      logic [127:0] r;
      logic [127:0] t;
      r = '0;
      for (int b = 34; b >= 0; b--) begin
        t = r | (128'd1 << b);
        if (t * t <= v) r = t;
      end
      return r[34:0];
    endfunction

    function res_t propagate(imu_item_t it);
      longint q [4];
      longint w [3];
      longint d [4];
      longint p [4];
      longint x, y, z, dx, dy, c, s, res, nwl, nql, v;
      logic [127:0] acc, big;
      logic [63:0]  m, prod;
      logic [34:0]  nw, nq;
      logic [31:0]  r;
      logic [1:0]   quad;
      res_t         o;
      for (int i = 0; i < 4; i++) q[i] = it.q[i];
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        w[i] = longint'(it.rate[i]) - longint'(it.bias[i]);
        if (w[i] > 64'sd2147483647) w[i] = 64'sd2147483647;
        if (w[i] < -64'sd2147483648) w[i] = -64'sd2147483648;
        m = (w[i] < 0) ? -w[i] : w[i];
        acc += {64'd0, m} * {64'd0, m};
      end
      nw = isqrt(acc);
      if (nw == 0) begin
        d[0] = ONE_Q30; d[1] = 0; d[2] = 0; d[3] = 0;
      end else begin
        prod = {29'd0, nw} * {40'd0, it.dt};
        big  = {64'd0, prod} * {64'd0, PHASE_K};
        r    = big[113:82] + EIGHTH_TURN;
        quad = r[31:30];
        res  = longint'({2'b00, r[29:0]}) - 64'sd536870912;
        z    = (res * longint'({32'd0, PI_Q30})) >>> 31;
        x    = longint'({32'd0, GAIN_Q30});
        y    = 0;
        for (int i = 0; i < CORDIC_N; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x -= dx; y += dy; z -= longint'({32'd0, ATAN_Q30[i]});
          end else begin
            x += dx; y -= dy; z += longint'({32'd0, ATAN_Q30[i]});
          end
        end
        case (quad)
          QUAD_I:   begin c = x;  s = y;  end
          QUAD_II:  begin c = -y; s = x;  end
          QUAD_III: begin c = -x; s = -y; end
          default:  begin c = y;  s = -x; end
        endcase
        nwl = longint'({29'd0, nw});
        d[0] = c;
        for (int i = 0; i < 3; i++) d[1 + i] = (w[i] * s) / nwl;
      end
      p[0] = ((q[0]*d[0]) >>> 30) - ((q[1]*d[1]) >>> 30) - ((q[2]*d[2]) >>> 30)
           - ((q[3]*d[3]) >>> 30);
      p[1] = ((q[0]*d[1]) >>> 30) + ((q[1]*d[0]) >>> 30) + ((q[2]*d[3]) >>> 30)
           - ((q[3]*d[2]) >>> 30);
      p[2] = ((q[0]*d[2]) >>> 30) - ((q[1]*d[3]) >>> 30) + ((q[2]*d[0]) >>> 30)
           + ((q[3]*d[1]) >>> 30);
      p[3] = ((q[0]*d[3]) >>> 30) + ((q[1]*d[2]) >>> 30) - ((q[2]*d[1]) >>> 30)
           + ((q[3]*d[0]) >>> 30);
      acc = '0;
      for (int i = 0; i < 4; i++) begin
        if (p[i] > 64'sd8589934591) p[i] = 64'sd8589934591;
        if (p[i] < -64'sd8589934591) p[i] = -64'sd8589934591;
        m = (p[i] < 0) ? -p[i] : p[i];
        acc += {64'd0, m} * {64'd0, m};
      end
      nq  = isqrt(acc);
      nql = longint'({29'd0, nq});
      for (int i = 0; i < 4; i++) begin
        v = 0;
        if (nq != 0) begin
          v = (p[i] * longint'({32'd0, ONE_Q30})) / nql;
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          if (v < -64'sd2147483648) v = -64'sd2147483648;
        end
        o[i] = v[31:0];
      end
      return o;
    endfunction

    function void note_item(imu_item_t it);
      pending.push_back(propagate(it));
    endfunction

    function void check_result(res_t got);
      res_t   want;
      string  names [4];
      names = '{"quat_w_out", "quat_x_out", "quat_y_out", "quat_z_out"};
      if (pending.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      matched++;
      for (int i = 0; i < 4; i++)
        if (want[i] !== got[i]) begin
          $error("%s expected %0d actual %0d", names[i], $signed(want[i]), $signed(got[i]));
          errors++;
        end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   sent;
  bit   busy_mode;

  gqi_in_if  in_if ();
  gqi_out_if out_if ();

  gyro_quaternion_integrate_core uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  attitude_board board = new();

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function int pick_gap();
    int r;
    if (busy_mode) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      board.note_item('{q: '{in_if.quat_w_in, in_if.quat_x_in, in_if.quat_y_in,
                             in_if.quat_z_in},
                        rate: '{in_if.rate_x, in_if.rate_y, in_if.rate_z},
                        bias: '{in_if.bias_x, in_if.bias_y, in_if.bias_z},
                        dt: in_if.step_time});
    if (rst_n && out_if.valid && out_if.ready)
      board.check_result({out_if.quat_z_out, out_if.quat_y_out, out_if.quat_x_out,
                          out_if.quat_w_out});
  end

  initial begin
    int g;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      g = pick_gap();
      if (g == 0) begin
        out_if.ready = 1'b1;
      end else begin
        out_if.ready = 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  task automatic send_item(imu_item_t it);
    int g;
    @(negedge clk);
    in_if.valid     = 1'b1;
    in_if.quat_w_in = it.q[0];
    in_if.quat_x_in = it.q[1];
    in_if.quat_y_in = it.q[2];
    in_if.quat_z_in = it.q[3];
    in_if.rate_x    = it.rate[0];
    in_if.rate_y    = it.rate[1];
    in_if.rate_z    = it.rate[2];
    in_if.bias_x    = it.bias[0];
    in_if.bias_y    = it.bias[1];
    in_if.bias_z    = it.bias[2];
    in_if.step_time = it.dt;
    do @(posedge clk); while (!in_if.ready);
    sent++;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_if.valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  function logic [31:0] rand_rate();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      2:       return $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
      default: return $signed($urandom_range(0, 1000)) - 500;
    endcase
  endfunction

  function imu_item_t rand_item();
    imu_item_t it;
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 4; i++)
      it.q[i] = (mode < 6) ? $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000
                           : $urandom;
    for (int i = 0; i < 3; i++) begin
      it.rate[i] = rand_rate();
      it.bias[i] = ($urandom_range(3) == 0) ? $urandom : ($urandom_range(0, 2000) - 1000);
    end
    if ($urandom_range(19) == 0) it.bias = '{it.rate[0], it.rate[1], it.rate[2]};
    it.dt = ($urandom_range(2) == 0) ? 24'($urandom) : 24'($urandom_range(0, 24'h00_8000));
    return it;
  endfunction

  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;
  localparam logic signed [31:0] ONEQ = 32'sh4000_0000;

  initial begin
    imu_item_t dir [$];
    int        wait_cycles;
    in_if.valid     = 1'b0;
    in_if.quat_w_in = '0; in_if.quat_x_in = '0; in_if.quat_y_in = '0; in_if.quat_z_in = '0;
    in_if.rate_x    = '0; in_if.rate_y    = '0; in_if.rate_z    = '0;
    in_if.bias_x    = '0; in_if.bias_y    = '0; in_if.bias_z    = '0;
    in_if.step_time = '0;
    sent = 0;
    busy_mode = 1'b0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    dir.push_back('{q: '{ONEQ, 0, 0, 0}, rate: '{0, 0, 0}, bias: '{0, 0, 0}, dt: 24'hFFFFFF});
    dir.push_back('{q: '{0, 0, 0, 0}, rate: '{32'sh0100_0000, 0, 0}, bias: '{0, 0, 0},
                    dt: 24'h01_0000});
    dir.push_back('{q: '{0, 0, 0, 0}, rate: '{0, 0, 0}, bias: '{0, 0, 0}, dt: 0});
    dir.push_back('{q: '{MAXV, MAXV, MAXV, MAXV}, rate: '{MAXV, MAXV, MAXV},
                    bias: '{MINV, MINV, MINV}, dt: 24'hFFFFFF});
    dir.push_back('{q: '{MINV, MINV, MINV, MINV}, rate: '{MINV, MINV, MINV},
                    bias: '{MAXV, MAXV, MAXV}, dt: 24'hFFFFFF});
    dir.push_back('{q: '{MINV, MAXV, MINV, MAXV}, rate: '{MAXV, MINV, MAXV},
                    bias: '{MINV, MAXV, MINV}, dt: 24'h80_0000});
    dir.push_back('{q: '{ONEQ, 0, 0, 0}, rate: '{32'sh0100_0000, 0, 0}, bias: '{0, 0, 0},
                    dt: 0});
    dir.push_back('{q: '{ONEQ, 0, 0, 0}, rate: '{1, 0, 0}, bias: '{0, 0, 0}, dt: 24'd1});
    dir.push_back('{q: '{ONEQ, 0, 0, 0}, rate: '{32'sh0300_0000, 32'sh0300_0000, 0},
                    bias: '{32'sh0300_0000, 32'sh0300_0000, 0}, dt: 24'hFFFFFF});
    dir.push_back('{q: '{0, ONEQ, 0, 0}, rate: '{0, 32'sh0648_7ED5, 0}, bias: '{0, 0, 0},
                    dt: 24'hFFFFFF});
    dir.push_back('{q: '{0, 0, ONEQ, 0}, rate: '{0, 0, -32'sh0C90_FDAA}, bias: '{0, 0, 0},
                    dt: 24'hFFFFFF});
    dir.push_back('{q: '{ONEQ, ONEQ, ONEQ, ONEQ}, rate: '{MAXV, 0, 0}, bias: '{0, 0, 0},
                    dt: 24'h00_0400});
    dir.push_back('{q: '{1, 0, 0, 0}, rate: '{0, 0, MINV}, bias: '{0, 0, 0}, dt: 24'h12_3456});
    dir.push_back('{q: '{-ONEQ, 0, 0, 0}, rate: '{5, -7, 3}, bias: '{2, 1, -1}, dt: 24'hFFFFFF});
    foreach (dir[i]) send_item(dir[i]);

    for (int n = 0; n < 1200; n++) begin
      if (n % 150 == 0) busy_mode = ($urandom_range(2) == 0);
      send_item(rand_item());
    end
    @(negedge clk);
    in_if.valid = 1'b0;
    busy_mode = 1'b0;

    wait_cycles = 0;
    while (board.pending.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (250) @(posedge clk);
    if (board.pending.size() != 0) begin
      $error("%0d results never arrived", board.pending.size());
      board.errors++;
    end
    $display("Covered %0d items (directed edges, saturation, zero norms) and %0d results",
             sent, board.matched);
    $display("with random gaps and output stalls on both channels.");
    if (board.errors == 0) begin
      $display("PASS gyro_quaternion_integrate_core");
    end else begin
      $display("FAIL gyro_quaternion_integrate_core");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("FAIL gyro_quaternion_integrate_core");
    $finish;
  end
endmodule
